// ===== design/dsq_pkg.sv =====
// Shared types, constants and elaboration-time threshold functions of the sector quantizer.
package dsq_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int COORD_BITS_MAX = 32;
  localparam int SECTOR_W       = 7;
  localparam int SUB_W          = 4;
  localparam int SUB_COUNT      = 16;
  localparam int GUARD_BITS     = 16;
  localparam int FRAC_MAX       = 2 * (COORD_BITS_MAX + 2) + GUARD_BITS;
  localparam int BIG_W          = 16 * (FRAC_MAX + 2);

  typedef logic [SECTOR_W-1:0] sector_t;
  typedef logic [SUB_W-1:0]    sub_t;
  typedef logic [FRAC_MAX-1:0] tan_t;
  typedef logic [BIG_W-1:0]    big_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  typedef struct packed {
    logic  zero;
    quad_e quad;
    logic  oct;
  } fold_t;

  function automatic int frac_bits(int coord_bits);
    return 2 * (coord_bits + 2) + GUARD_BITS;
  endfunction

  // Exact sub-sector of a first-octant vector, found by repeated angle doubling.
  function automatic sub_t octant_sub(big_t x_in, big_t y_in);
    big_t x;
    big_t y;
    big_t p;
    big_t s;
    big_t m;
    sub_t r;
    x = x_in;
    y = y_in;
    r = '0;
    for (int k = 0; k < SUB_W; k++) begin
      p = x * x;
      s = y * y;
      m = x * y;
      x = p - s;
      y = m << 1;
      r = {r[SUB_W-2:0], (y >= x)};
      if ((y >= x) && (k < SUB_W - 1)) begin
        p = x + y;
        s = y - x;
        x = p;
        y = s;
      end
    end
    return r;
  endfunction

  // Smallest tangent word above the lower edge of sub-sector j, at FRAC_MAX fraction bits.
  function automatic tan_t tan_thr(int j);
    big_t one;
    tan_t t;
    tan_t cand;
    one = big_t'(1) << FRAC_MAX;
    t   = '0;
    for (int b = FRAC_MAX - 1; b >= 0; b--) begin
      cand = t | (tan_t'(1) << b);
      if (octant_sub(one, big_t'(cand)) < sub_t'(j)) begin
        t = cand;
      end
    end
    return t + tan_t'(1);
  endfunction

endpackage

// ===== design/dsq_if.sv =====
// Valid/ready channel interfaces for point pair words and sector words.
interface dsq_pair_if #(
  parameter int COORD_BITS = dsq_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] a_x;
  logic signed [COORD_BITS-1:0] a_y;
  logic signed [COORD_BITS-1:0] b_x;
  logic signed [COORD_BITS-1:0] b_y;

  modport source (output valid, output a_x, output a_y, output b_x, output b_y, input ready);
  modport sink (input valid, input a_x, input a_y, input b_x, input b_y, output ready);
endinterface

interface dsq_sector_if;
  import dsq_pkg::*;

  logic    valid;
  logic    ready;
  sector_t sector_index;

  modport source (output valid, output sector_index, input ready);
  modport sink (input valid, input sector_index, output ready);
endinterface

// ===== design/dsq_fold.sv =====
// Difference vector, quadrant and octant folding into the first octant.
module dsq_fold #(
  parameter int COORD_BITS = dsq_pkg::COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0] a_x_i,
  input  logic signed [COORD_BITS-1:0] a_y_i,
  input  logic signed [COORD_BITS-1:0] b_x_i,
  input  logic signed [COORD_BITS-1:0] b_y_i,
  output dsq_pkg::fold_t               fold_o,
  output logic [COORD_BITS+1:0]        u_o,
  output logic [COORD_BITS+1:0]        v_o
);
  import dsq_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int UW = COORD_BITS + 2;

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic [DW-1:0]        ndx;
  logic [DW-1:0]        ndy;
  logic [DW-1:0]        qu;
  logic [DW-1:0]        qv;
  logic                 dx_pos;
  logic                 dx_neg;
  logic                 dy_pos;
  logic                 dy_neg;
  logic                 oct;
  quad_e                quad;

  assign dx  = DW'(a_x_i) - DW'(b_x_i);
  assign dy  = DW'(a_y_i) - DW'(b_y_i);
  assign ndx = DW'(-dx);
  assign ndy = DW'(-dy);

  always_comb begin
    dx_neg = dx[DW-1];
    dy_neg = dy[DW-1];
    dx_pos = !dx[DW-1] && (dx != '0);
    dy_pos = !dy[DW-1] && (dy != '0);
    if (dx_pos && !dy_neg) begin
      quad = QUAD_0;
      qu   = DW'(dx);
      qv   = DW'(dy);
    end else if (!dx_pos && dy_pos) begin
      quad = QUAD_1;
      qu   = DW'(dy);
      qv   = ndx;
    end else if (dx_neg && !dy_pos) begin
      quad = QUAD_2;
      qu   = ndx;
      qv   = ndy;
    end else begin
      quad = QUAD_3;
      qu   = ndy;
      qv   = DW'(dx);
    end
    oct = (qv >= qu);
    if (oct) begin
      u_o = UW'(qu) + UW'(qv);
      v_o = UW'(qv) - UW'(qu);
    end else begin
      u_o = UW'(qu);
      v_o = UW'(qv);
    end
    fold_o.zero = (dx == '0) && (dy == '0);
    fold_o.quad = quad;
    fold_o.oct  = oct;
  end

endmodule

// ===== design/dsq_sub_cmp.sv =====
// Fifteen tangent threshold compares and a binary search that yields the sub-sector.
module dsq_sub_cmp #(
  parameter int COORD_BITS = dsq_pkg::COORD_BITS_DEF
) (
  input  logic [COORD_BITS+1:0] u_i,
  input  logic [COORD_BITS+1:0] v_i,
  output dsq_pkg::sub_t         sub_o
);
  import dsq_pkg::*;

  localparam int UW    = COORD_BITS + 2;
  localparam int FW    = frac_bits(COORD_BITS);
  localparam int SHIFT = FRAC_MAX - FW;
  localparam int PW    = UW + FW;

  logic [SUB_COUNT-1:0] ge;
  logic [PW-1:0]        v_scaled;
  sub_t                 idx;

  assign ge[0]    = 1'b1;
  assign v_scaled = {v_i, {FW{1'b0}}};

  for (genvar j = 1; j < SUB_COUNT; j++) begin : g_thr
    localparam tan_t THR_MAX  = tan_thr(j);
    localparam tan_t REM_MASK = (tan_t'(1) << SHIFT) - tan_t'(1);
    localparam tan_t THR_CEIL = (THR_MAX >> SHIFT) + tan_t'((THR_MAX & REM_MASK) != '0);
    localparam logic [FW-1:0] THR = THR_CEIL[FW-1:0];

    assign ge[j] = (v_scaled >= (PW'(u_i) * PW'(THR)));
  end

  always_comb begin
    idx = '0;
    for (int b = SUB_W - 1; b >= 0; b--) begin
      if (ge[idx | (sub_t'(1) << b)]) begin
        idx = idx | (sub_t'(1) << b);
      end
    end
    sub_o = idx;
  end

endmodule

// ===== design/direction_sector_quantizer_core.sv =====
// Top level of the direction sector quantizer. Each accepted word carries two
// points A and B, and the result word gives the direction of A seen from B in
// 128ths of a full turn, exact to the last sector, with a zero vector giving
// sector 0. A new word can be taken in every cycle while result words are taken;
// the pair passes through an input register and a result register, with the
// quadrant and octant folding and fifteen parallel tangent threshold compares
// between them. The threshold constants are computed during elaboration, so
// no clearing or loading takes place after reset.
module direction_sector_quantizer_core #(
  parameter int COORD_BITS = dsq_pkg::COORD_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dsq_pair_if.sink     pair_i,
  dsq_sector_if.source sector_o
);
  import dsq_pkg::*;

  localparam int UW = COORD_BITS + 2;

  logic                         in_valid_q;
  logic                         out_valid_q;
  logic signed [COORD_BITS-1:0] a_x_q;
  logic signed [COORD_BITS-1:0] a_y_q;
  logic signed [COORD_BITS-1:0] b_x_q;
  logic signed [COORD_BITS-1:0] b_y_q;
  sector_t                      sector_q;
  sector_t                      sector_d;
  logic                         advance;
  fold_t                        fold;
  logic [UW-1:0]                u;
  logic [UW-1:0]                v;
  sub_t                         sub;

  assign advance      = !out_valid_q || sector_o.ready;
  assign pair_i.ready = !in_valid_q || advance;

  dsq_fold #(
    .COORD_BITS(COORD_BITS)
  ) u_fold (
    .a_x_i (a_x_q),
    .a_y_i (a_y_q),
    .b_x_i (b_x_q),
    .b_y_i (b_y_q),
    .fold_o(fold),
    .u_o   (u),
    .v_o   (v)
  );

  dsq_sub_cmp #(
    .COORD_BITS(COORD_BITS)
  ) u_sub_cmp (
    .u_i  (u),
    .v_i  (v),
    .sub_o(sub)
  );

  assign sector_d = fold.zero ? '0 : {fold.quad, fold.oct, sub};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pair_i.ready) begin
        in_valid_q <= pair_i.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pair_i.valid && pair_i.ready) begin
      a_x_q <= pair_i.a_x;
      a_y_q <= pair_i.a_y;
      b_x_q <= pair_i.b_x;
      b_y_q <= pair_i.b_y;
    end
    if (advance && in_valid_q) begin
      sector_q <= sector_d;
    end
  end

  assign sector_o.valid        = out_valid_q;
  assign sector_o.sector_index = sector_q;

endmodule

// ===== design/dsq_checker.sv =====
// Port-level assertions for the sector quantizer and the bind that attaches them.
module dsq_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input dsq_pkg::sector_t sector_index_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(sector_index_i))
    else $error("Stalled result word changed or was dropped.");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("Input stalled although no result word is waiting.");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> ##2 out_valid_i)
    else $error("No result word two cycles after an accepted word.");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("Result word appeared without an accepted input word.");

endmodule

bind direction_sector_quantizer_core dsq_checker u_dsq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (pair_i.valid),
  .in_ready_i    (pair_i.ready),
  .out_valid_i   (sector_o.valid),
  .out_ready_i   (sector_o.ready),
  .sector_index_i(sector_o.sector_index)
);
